// ===== hdl/ppid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared widths, codes, control word layout, microcode program and saturation
// helpers for the positional PID core with a filtered derivative.
// ----------------------------------------------------------------------------
package ppid_pkg;

	localparam int E_W        = 16;
	localparam int DIFF_W     = E_W + 1;
	localparam int SUM_W      = 32;
	localparam int SLOPE_W    = 24;
	localparam int GAIN_W     = 16;
	localparam int ALPHA_W    = 17;
	localparam int CAP_W      = 31;
	localparam int DRIVE_W    = 32;
	localparam int MUL_A_W    = SUM_W;
	localparam int MUL_B_W    = ALPHA_W + 1;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int ACC_W      = PROD_W;
	localparam int SLOPE_SH   = 16;
	localparam int DRIVE_SH   = 8;
	localparam int CAP_SH     = 8;
	localparam int DIVD_W     = CAP_W + CAP_SH;
	localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
	localparam int PC_W       = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = CAP_W;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
	localparam logic [GAIN_W-1:0]  GAIN_RST  = '0;
	localparam logic [CAP_W-1:0]   CAP_RST   = {CAP_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_SMOOTHING = 3'd3,
		REG_CAP       = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [ALPHA_W-1:0] smoothing;
		logic [CAP_W-1:0]   integral_cap;
	} cfg_t;

	typedef enum logic [1:0] {
		MA_E, MA_DIFF, MA_SLOPE, MA_SUM
	} mul_a_t;

	typedef enum logic [2:0] {
		MB_ALPHA, MB_BETA, MB_GP, MB_GI, MB_GD
	} mul_b_t;

	typedef enum logic [1:0] {
		ACC_HOLD, ACC_LOAD, ACC_ADD
	} acc_op_t;

	typedef enum logic [2:0] {
		A_NONE, A_LATCH, A_SUM_ADD, A_DIV_INIT, A_SLOPE_SET, A_DIV_STEP,
		A_SUM_CLAMP, A_OUT
	} act_t;

	typedef enum logic [2:0] {
		C_NEXT, C_ALWAYS, C_NO_IN, C_GI_ZERO, C_DIV_MORE, C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		mul_a_t          ma;
		mul_b_t          mb;
		acc_op_t         acc;
		act_t            act;
		cond_t           cond;
		logic [PC_W-1:0] tgt;
	} uword_t;

	typedef struct packed {
		logic in_fire;
		logic out_busy;
		logic gi_zero;
		logic div_more;
	} seq_stat_t;

	// program addresses used as jump targets
	localparam logic [PC_W-1:0] ST_WAIT = PC_W'(0);
	localparam logic [PC_W-1:0] ST_DIV  = PC_W'(5);
	localparam logic [PC_W-1:0] ST_MAC  = PC_W'(7);
	localparam logic [PC_W-1:0] ST_OUT  = PC_W'(11);

	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{MA_E, MB_ALPHA, ACC_HOLD, A_NONE, C_ALWAYS, ST_WAIT};
		case (pc)
			PC_W'(0):  w = '{MA_E,     MB_ALPHA, ACC_HOLD, A_LATCH,     C_NO_IN,    ST_WAIT};
			PC_W'(1):  w = '{MA_DIFF,  MB_ALPHA, ACC_HOLD, A_SUM_ADD,   C_NEXT,     ST_WAIT};
			PC_W'(2):  w = '{MA_SLOPE, MB_BETA,  ACC_LOAD, A_DIV_INIT,  C_NEXT,     ST_WAIT};
			PC_W'(3):  w = '{MA_E,     MB_ALPHA, ACC_ADD,  A_NONE,      C_NEXT,     ST_WAIT};
			PC_W'(4):  w = '{MA_E,     MB_ALPHA, ACC_HOLD, A_SLOPE_SET, C_GI_ZERO,  ST_MAC};
			PC_W'(5):  w = '{MA_E,     MB_ALPHA, ACC_HOLD, A_DIV_STEP,  C_DIV_MORE, ST_DIV};
			PC_W'(6):  w = '{MA_E,     MB_ALPHA, ACC_HOLD, A_SUM_CLAMP, C_NEXT,     ST_WAIT};
			PC_W'(7):  w = '{MA_E,     MB_GP,    ACC_HOLD, A_NONE,      C_NEXT,     ST_WAIT};
			PC_W'(8):  w = '{MA_SUM,   MB_GI,    ACC_LOAD, A_NONE,      C_NEXT,     ST_WAIT};
			PC_W'(9):  w = '{MA_SLOPE, MB_GD,    ACC_ADD,  A_NONE,      C_NEXT,     ST_WAIT};
			PC_W'(10): w = '{MA_E,     MB_ALPHA, ACC_ADD,  A_NONE,      C_NEXT,     ST_WAIT};
			PC_W'(11): w = '{MA_E,     MB_ALPHA, ACC_HOLD, A_OUT,       C_OUT_BUSY, ST_OUT};
			default:   w = '{MA_E,     MB_ALPHA, ACC_HOLD, A_NONE,      C_ALWAYS,   ST_WAIT};
		endcase
		return w;
	endfunction

	function automatic logic signed [SLOPE_W-1:0] sat_slope(
		input logic signed [ACC_W-SLOPE_SH-1:0] x
	);
		logic s;
		s = x[ACC_W-SLOPE_SH-1];
		if (x[ACC_W-SLOPE_SH-1:SLOPE_W-1] != {(ACC_W-SLOPE_SH-SLOPE_W+1){s}})
			return s ? {1'b1, {(SLOPE_W-1){1'b0}}} : {1'b0, {(SLOPE_W-1){1'b1}}};
		return x[SLOPE_W-1:0];
	endfunction

	function automatic logic signed [DRIVE_W-1:0] sat_drive(
		input logic signed [ACC_W-DRIVE_SH-1:0] x
	);
		logic s;
		s = x[ACC_W-DRIVE_SH-1];
		if (x[ACC_W-DRIVE_SH-1:DRIVE_W-1] != {(ACC_W-DRIVE_SH-DRIVE_W+1){s}})
			return s ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
		return x[DRIVE_W-1:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(
		input logic signed [SUM_W:0] x
	);
		if (x[SUM_W] != x[SUM_W-1])
			return x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		return x[SUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/ppid_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppid_if
// Valid/ready channels of the PID core: error samples in, drive values out.
// ----------------------------------------------------------------------------
interface ppid_in_if;
	import ppid_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [E_W-1:0]   error_sample;

	modport source (output valid, output error_sample, input ready);
	modport sink   (input valid, input error_sample, output ready);
endinterface

interface ppid_out_if;
	import ppid_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;

	modport source (output valid, output drive, input ready);
	modport sink   (input valid, input drive, output ready);
endinterface
`default_nettype wire

// ===== hdl/ppid_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppid_div
// Restoring divider, one quotient bit per step: (integral_cap << 8) / gain_i.
// ----------------------------------------------------------------------------
module ppid_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic                        step,
	input  wire logic [ppid_pkg::CAP_W-1:0]  cap,
	input  wire logic [ppid_pkg::GAIN_W-1:0] divisor,
	output logic [ppid_pkg::DIVD_W-1:0]      quotient,
	output logic                             more
);
	import ppid_pkg::*;

	logic [GAIN_W-1:0]    rem_q;
	logic [DIVD_W-1:0]    dq_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [GAIN_W:0]      cand;
	logic [GAIN_W:0]      diff;
	logic                 ge;

	assign cand = {rem_q, dq_q[DIVD_W-1]};
	assign ge   = cand >= {1'b0, divisor};
	assign diff = cand - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIVD_W);
		end else if (step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// dividend bits shift out the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= {cap, {CAP_SH{1'b0}}};
		end else if (step) begin
			rem_q <= ge ? diff[GAIN_W-1:0] : cand[GAIN_W-1:0];
			dq_q  <= {dq_q[DIVD_W-2:0], ge};
		end
	end

	assign quotient = dq_q;
	assign more     = cnt_q != DIV_CNT_W'(1);

endmodule
`default_nettype wire

// ===== hdl/ppid_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppid_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
module ppid_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ppid_pkg::seq_stat_t stat,
	output ppid_pkg::uword_t         uw
);
	import ppid_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_nxt;
	logic            jump;

	assign uw = ucode_rom(pc_q);

	always_comb begin
		unique case (uw.cond)
			C_NEXT:     jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_IN:    jump = !stat.in_fire;
			C_GI_ZERO:  jump = stat.gi_zero;
			C_DIV_MORE: jump = stat.div_more;
			C_OUT_BUSY: jump = stat.out_busy;
			default:    jump = 1'b1;
		endcase
		pc_nxt = jump ? uw.tgt : pc_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_WAIT;
		end else begin
			pc_q <= pc_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ppid_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ppid_dpath
// Datapath driven by the control word: shared multiplier, accumulator,
// controller state, integral clamp and the output register.
// ----------------------------------------------------------------------------
module ppid_dpath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ppid_pkg::cfg_t   cfg,
	input  wire ppid_pkg::uword_t uw,
	output ppid_pkg::seq_stat_t   stat,
	ppid_in_if.sink               samples,
	ppid_out_if.source            drives
);
	import ppid_pkg::*;

	logic signed [E_W-1:0]     e_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic [ALPHA_W-1:0]        alpha_q;
	logic signed [E_W-1:0]     last_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [SLOPE_W-1:0] slope_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic                      out_valid_q;

	logic                      in_fire;
	logic                      out_busy;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [ALPHA_W-1:0]        mul_b;
	logic signed [MUL_B_W-1:0] mul_b_s;
	logic signed [PROD_W-1:0]  prod_c;
	logic [ALPHA_W-1:0]        beta;
	logic signed [ACC_W-1:0]   slope_rnd;
	logic signed [ACC_W-1:0]   drive_rnd;
	logic [DIVD_W-1:0]         quotient;
	logic                      div_more;
	logic [CAP_W-1:0]          lim;
	logic signed [SUM_W-1:0]   lim_pos;
	logic signed [SUM_W-1:0]   lim_neg;

	assign samples.ready = uw.act == A_LATCH;
	assign in_fire       = samples.valid && samples.ready;
	assign out_busy      = out_valid_q && !drives.ready;

	assign stat.in_fire  = in_fire;
	assign stat.out_busy = out_busy;
	assign stat.gi_zero  = cfg.gain_i == '0;
	assign stat.div_more = div_more;

	ppid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (uw.act == A_DIV_INIT),
		.step     (uw.act == A_DIV_STEP),
		.cap      (cfg.integral_cap),
		.divisor  (cfg.gain_i),
		.quotient (quotient),
		.more     (div_more)
	);

	assign beta = ALPHA_ONE - alpha_q;

	always_comb begin
		case (uw.ma)
			MA_E:     mul_a = MUL_A_W'(e_q);
			MA_DIFF:  mul_a = MUL_A_W'(diff_q);
			MA_SLOPE: mul_a = MUL_A_W'(slope_q);
			MA_SUM:   mul_a = sum_q;
			default:  mul_a = '0;
		endcase
		case (uw.mb)
			MB_ALPHA: mul_b = alpha_q;
			MB_BETA:  mul_b = beta;
			MB_GP:    mul_b = ALPHA_W'(cfg.gain_p);
			MB_GI:    mul_b = ALPHA_W'(cfg.gain_i);
			MB_GD:    mul_b = ALPHA_W'(cfg.gain_d);
			default:  mul_b = '0;
		endcase
	end

	assign mul_b_s = $signed({1'b0, mul_b});
	assign prod_c  = mul_a * mul_b_s;

	// round to nearest, ties toward plus infinity, then take the high bits
	assign slope_rnd = acc_q + ACC_W'(1 << (SLOPE_SH - 1));
	assign drive_rnd = acc_q + ACC_W'(1 << (DRIVE_SH - 1));

	// sum limit is the quotient capped at the largest positive 32-bit value
	assign lim     = (|quotient[DIVD_W-1:CAP_W]) ? {CAP_W{1'b1}} : quotient[CAP_W-1:0];
	assign lim_pos = $signed({1'b0, lim});
	assign lim_neg = -lim_pos;

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		case (uw.acc)
			ACC_LOAD: acc_q <= prod_q;
			ACC_ADD:  acc_q <= acc_q + prod_q;
			default:  acc_q <= acc_q;
		endcase
		if (in_fire) begin
			e_q     <= samples.error_sample;
			diff_q  <= DIFF_W'(samples.error_sample) - DIFF_W'(last_q);
			alpha_q <= (cfg.smoothing > ALPHA_ONE) ? ALPHA_ONE : cfg.smoothing;
		end
		if (uw.act == A_OUT && !out_busy) begin
			drive_q <= sat_drive(drive_rnd[ACC_W-1:DRIVE_SH]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= '0;
			sum_q       <= '0;
			slope_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				last_q <= samples.error_sample;
			end
			case (uw.act)
				A_SUM_ADD: begin
					sum_q <= sat_sum((SUM_W+1)'(sum_q) + (SUM_W+1)'(e_q));
				end
				A_SLOPE_SET: begin
					slope_q <= sat_slope(slope_rnd[ACC_W-1:SLOPE_SH]);
				end
				A_SUM_CLAMP: begin
					if (sum_q > lim_pos) begin
						sum_q <= lim_pos;
					end else if (sum_q < lim_neg) begin
						sum_q <= lim_neg;
					end
				end
				default: begin
				end
			endcase
			// hold the beat until taken; a new one may load as the old leaves
			if (uw.act == A_OUT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (drives.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign drives.valid = out_valid_q;
	assign drives.drive = drive_q;

endmodule
`default_nettype wire

// ===== hdl/positional_pid_filtered_derivative_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// positional_pid_filtered_derivative_core
// Positional PID controller in fixed point with a low-pass filtered
// derivative and a clamped integral, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  samples   in   valid/ready      error_sample  s16 Q8.8
//  drives    out  valid/ready      drive         s32 Q.8
//  cfg       in   cfg_we           cfg_index 3b, cfg_data 31b
//
//  The 39-step restoring divider for the integral limit runs for each sample
//  while gain_i is nonzero; with gain_i zero the sequencer skips it and the
//  clamp. Samples are taken one at a time, and the next one is accepted
//  while the previous drive still waits in the output register.
//  A stalled output holds the sequencer at its last step. Reset is immediate:
//  no clearing pass.
// ----------------------------------------------------------------------------
module positional_pid_filtered_derivative_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ppid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ppid_pkg::CFG_DATA_W-1:0] cfg_data,
	ppid_in_if.sink                              samples,
	ppid_out_if.source                           drives
);
	import ppid_pkg::*;

	cfg_t      cfg_q;
	uword_t    uw;
	seq_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p       <= GAIN_RST;
			cfg_q.gain_i       <= GAIN_RST;
			cfg_q.gain_d       <= GAIN_RST;
			cfg_q.smoothing    <= ALPHA_ONE;
			cfg_q.integral_cap <= CAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_GAIN_P:    cfg_q.gain_p       <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:    cfg_q.gain_i       <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:    cfg_q.gain_d       <= cfg_data[GAIN_W-1:0];
				REG_SMOOTHING: cfg_q.smoothing    <= cfg_data[ALPHA_W-1:0];
				REG_CAP:       cfg_q.integral_cap <= cfg_data[CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ppid_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.uw     (uw)
	);

	ppid_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.uw      (uw),
		.stat    (stat),
		.samples (samples),
		.drives  (drives)
	);

endmodule
`default_nettype wire

// ===== tb/positional_pid_filtered_derivative_core_test.sv =====
// ----------------------------------------------------------------------------
// positional_pid_filtered_derivative_core_test
// Self-checking bench for the fixed-point positional PID core. A short table
// of directed samples and register writes comes first, then randomized
// segments under varying gains, smoothing and integral caps with different
// idle patterns on both channels, and last a short unclamped integral run
// that then switches the integral gain on. Every drive beat is compared in
// order with a local model of the controller state.
// ----------------------------------------------------------------------------
module positional_pid_filtered_derivative_core_test;
	import ppid_pkg::*;

	localparam int DRAIN_CYCLES = 64;
	localparam int SEGMENTS     = 8;
	localparam int SEG_ITEMS    = 236;
	localparam int WINDUP_ITEMS = 24;
	localparam int HOLD_CYCLES  = 600;

	// indexes past the register file; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0]  REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0]  REG_SPARE_HI = 3'd7;
	localparam logic signed [E_W-1:0] E_MAX        = 16'sh7FFF;
	localparam logic signed [E_W-1:0] E_MIN        = 16'sh8000;
	localparam logic [CFG_DATA_W-1:0] DATA_ONES    = '1;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [CFG_IDX_W-1:0]     idx;
		logic [CFG_DATA_W-1:0]    data;
		logic signed [E_W-1:0]    err;
		logic                     known;
		logic signed [DRIVE_W-1:0] want;
	} plan_row_t;

	typedef struct packed {
		logic                      known;
		logic signed [DRIVE_W-1:0] want;
	} typed_t;

	localparam int PLAN_LEN = 31;
	plan_row_t plan [PLAN_LEN] = '{
		// all gains zero out of reset
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MAX,     1'b1, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MIN,     1'b1, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         '0,        1'b1, '0},
		'{ROW_WRITE,  REG_SPARE_LO,  DATA_ONES,  '0,        1'b0, '0},
		'{ROW_WRITE,  REG_SPARE_HI,  DATA_ONES,  '0,        1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         16'sd1,    1'b1, '0},
		// zero cap pins the sum at zero
		'{ROW_WRITE,  REG_GAIN_I,    DATA_ONES,  '0,        1'b0, '0},
		'{ROW_WRITE,  REG_CAP,       '0,         '0,        1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MAX,     1'b1, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MIN,     1'b1, '0},
		'{ROW_WRITE,  REG_GAIN_P,    31'd65535,  '0,        1'b0, '0},
		'{ROW_WRITE,  REG_GAIN_D,    DATA_ONES,  '0,        1'b0, '0},
		'{ROW_WRITE,  REG_CAP,       DATA_ONES,  '0,        1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MAX,     1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MIN,     1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MAX,     1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MIN,     1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         '0,        1'b0, '0},
		// alpha zero freezes the slope
		'{ROW_WRITE,  REG_SMOOTHING, '0,         '0,        1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MAX,     1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MIN,     1'b0, '0},
		// alpha above one acts as no filtering
		'{ROW_WRITE,  REG_SMOOTHING, DATA_ONES,  '0,        1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MAX,     1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MIN,     1'b0, '0},
		'{ROW_WRITE,  REG_SMOOTHING, 31'd32768,  '0,        1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MAX,     1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MAX,     1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         -16'sd1,   1'b0, '0},
		// zero integral gain: no clamp
		'{ROW_WRITE,  REG_GAIN_I,    '0,         '0,        1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MIN,     1'b0, '0},
		'{ROW_SAMPLE, REG_GAIN_P,    '0,         E_MAX,     1'b0, '0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ppid_in_if  sample_ch ();
	ppid_out_if drive_ch ();

	positional_pid_filtered_derivative_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (sample_ch),
		.drives    (drive_ch)
	);

	// controller copy: registers and state
	logic [GAIN_W-1:0]         k_gp    = GAIN_RST;
	logic [GAIN_W-1:0]         k_gi    = GAIN_RST;
	logic [GAIN_W-1:0]         k_gd    = GAIN_RST;
	logic [ALPHA_W-1:0]        k_alpha = ALPHA_ONE;
	logic [CAP_W-1:0]          k_cap   = CAP_RST;
	logic signed [E_W-1:0]     p_last  = '0;
	logic signed [SUM_W-1:0]   p_sum   = '0;
	logic signed [SLOPE_W-1:0] p_slope = '0;

	logic signed [DRIVE_W-1:0] drive_q [$];
	typed_t                    typed_q [$];

	int snd_idle_pct  = 0;
	int rcv_stall_pct = 0;
	int hold_req      = 0;
	int fails         = 0;
	int n_samples     = 0;
	int n_checked     = 0;
	int n_writes      = 0;

	function automatic longint bound(input longint x, input longint lo, input longint hi);
		if (x < lo)
			return lo;
		if (x > hi)
			return hi;
		return x;
	endfunction

	// advance the controller by one error sample, return the drive it yields
	function automatic logic signed [DRIVE_W-1:0] pid_drive(input logic signed [E_W-1:0] e);
		longint ev;
		longint alpha;
		longint slope;
		longint sum;
		longint lim;
		longint acc;
		ev = e;
		alpha = (k_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(k_alpha);
		slope = (ev - longint'(p_last)) * alpha + longint'(p_slope) * (65536 - alpha) + 32768;
		slope = bound(slope >>> SLOPE_SH, -8388608, 8388607);
		p_slope = slope[SLOPE_W-1:0];
		p_last = e;
		sum = bound(longint'(p_sum) + ev, -64'sd2147483648, 64'sd2147483647);
		if (k_gi != '0) begin
			lim = (longint'(k_cap) << CAP_SH) / longint'(k_gi);
			if (lim > 64'sd2147483647)
				lim = 64'sd2147483647;
			sum = bound(sum, -lim, lim);
		end
		p_sum = sum[SUM_W-1:0];
		acc = longint'(k_gp) * ev + longint'(k_gi) * sum + longint'(k_gd) * slope;
		acc = bound((acc + 128) >>> DRIVE_SH, -64'sd2147483648, 64'sd2147483647);
		return acc[DRIVE_W-1:0];
	endfunction

	function automatic logic [GAIN_W-1:0] draw_gain();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return '1;
			2: return GAIN_W'($urandom_range(1, 16));
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	task automatic push_sample(input logic signed [E_W-1:0] e);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.error_sample <= e;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(
		input logic [GAIN_W-1:0]  gp,
		input logic [GAIN_W-1:0]  gi,
		input logic [GAIN_W-1:0]  gd,
		input logic [ALPHA_W-1:0] al,
		input logic [CAP_W-1:0]   cap
	);
		write_reg(REG_GAIN_P, CFG_DATA_W'(gp));
		write_reg(REG_GAIN_I, CFG_DATA_W'(gi));
		write_reg(REG_GAIN_D, CFG_DATA_W'(gd));
		write_reg(REG_SMOOTHING, CFG_DATA_W'(al));
		write_reg(REG_CAP, CFG_DATA_W'(cap));
	endtask

	// drop valid, drain all pending drives, then let the sequencer go quiet
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("simulation failed");
		$finish;
	end

	// receiver: random stalls, or a counted hold-off when requested
	initial begin
		drive_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				for (int n = 0; n < hold_req; n++) begin
					drive_ch.ready <= 1'b0;
					@(posedge clk);
				end
				hold_req = 0;
			end else begin
				drive_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		logic signed [DRIVE_W-1:0] want;
		typed_t                    tv;
		if (arst_n) begin
			if (drive_ch.valid && drive_ch.ready) begin
				if (drive_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected drive beat, got %0d", $time, drive_ch.drive);
				end else begin
					want = drive_q.pop_front();
					n_checked++;
					if (drive_ch.drive !== want) begin
						fails++;
						$display("%0t: drive mismatch, expected %0d, got %0d",
							$time, want, drive_ch.drive);
					end
				end
			end
			if (cfg_we) begin
				n_writes++;
				case (cfg_index)
					REG_GAIN_P:    k_gp = cfg_data[GAIN_W-1:0];
					REG_GAIN_I:    k_gi = cfg_data[GAIN_W-1:0];
					REG_GAIN_D:    k_gd = cfg_data[GAIN_W-1:0];
					REG_SMOOTHING: k_alpha = cfg_data[ALPHA_W-1:0];
					REG_CAP:       k_cap = cfg_data[CAP_W-1:0];
					default: ;
				endcase
			end
			if (sample_ch.valid && sample_ch.ready) begin
				want = pid_drive(sample_ch.error_sample);
				if (typed_q.size() != 0) begin
					tv = typed_q.pop_front();
					if (tv.known)
						want = tv.want;
				end
				drive_q.push_back(want);
				n_samples++;
			end
		end
	end

	initial begin
		logic [GAIN_W-1:0]     gp;
		logic [GAIN_W-1:0]     gi;
		logic [GAIN_W-1:0]     gd;
		logic [ALPHA_W-1:0]    al;
		logic [CAP_W-1:0]      cap;
		logic signed [E_W-1:0] e;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_GAIN_P;
		cfg_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.error_sample <= '0;
		e = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_WRITE) begin
				settle();
				write_reg(plan[r].idx, plan[r].data);
			end else begin
				typed_q.push_back(typed_t'{plan[r].known, plan[r].want});
				push_sample(plan[r].err);
			end
		end
		settle();

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 75; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 75; end
				default: begin snd_idle_pct = 15; rcv_stall_pct = 15; end
			endcase
			gp = draw_gain();
			gi = draw_gain();
			gd = draw_gain();
			case ($urandom_range(0, 3))
				0: al = '0;
				1: al = ALPHA_ONE;
				2: al = ALPHA_W'($urandom_range(65537, 131071));
				default: al = ALPHA_W'($urandom_range(0, 65536));
			endcase
			case ($urandom_range(0, 3))
				0: cap = '0;
				1: cap = CAP_RST;
				2: cap = CAP_W'($urandom_range(0, 1 << 20));
				default: cap = CAP_W'($urandom);
			endcase
			configure(gp, gi, gd, al, cap);
			// fill the core while the drive side holds off
			if (seg == 4)
				hold_req = HOLD_CYCLES;
			for (int k = 0; k < SEG_ITEMS; k++) begin
				case ($urandom_range(0, 3))
					0: e = E_W'($urandom);
					1: e = E_W'($urandom_range(0, 1023) - 512);
					2: e = $urandom_range(0, 1) ? E_MAX : E_MIN;
					default: ;
				endcase
				push_sample(e);
			end
			settle();
		end

		// build up an unclamped sum, then expose it through the integral gain
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		configure(16'd256, '0, 16'd256, ALPHA_ONE, CAP_RST);
		for (int k = 0; k < WINDUP_ITEMS; k++)
			push_sample(E_MAX);
		settle();
		write_reg(REG_GAIN_I, CFG_DATA_W'(1));
		push_sample('0);
		push_sample(E_MIN);
		push_sample(E_MAX);
		push_sample('0);
		settle();

		if (drive_q.size() != 0) begin
			fails++;
			$display("%0t: %0d drive beats never arrived", $time, drive_q.size());
		end
		$display("covered %0d error samples and %0d register writes, incl. an unclamped sum run",
			n_samples, n_writes);
		$display("compared %0d drive beats, %0d failures", n_checked, fails);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/ppid_pkg.sv
hdl/ppid_if.sv
hdl/ppid_div.sv
hdl/ppid_seq.sv
hdl/ppid_dpath.sv
hdl/positional_pid_filtered_derivative_core.sv
tb/positional_pid_filtered_derivative_core_test.sv
